[hw/rtl/ertt_pkg.sv]
// Shared types and constants for the echo range target tracker.
`timescale 1ns / 1ps
package ertt_pkg;
	localparam logic [1:0] MODE_SCAN     = 2'd0;
	localparam logic [1:0] MODE_NUDGE    = 2'd1;
	localparam logic [1:0] MODE_SNAKE    = 2'd2;
	localparam logic [1:0] MODE_EDGE     = 2'd3;

	localparam logic [2:0] REG_TRACK_MODE = 3'd0;
	localparam logic [2:0] REG_NEAR       = 3'd1;
	localparam logic [2:0] REG_CONTACT    = 3'd2;
	localparam logic [2:0] REG_COMMIT     = 3'd3;
	localparam logic [2:0] REG_BACKUP_EN  = 3'd4;
	localparam logic [2:0] REG_BACKUP_AFT = 3'd5;
	localparam logic [2:0] REG_GRACE      = 3'd6;
	localparam logic [2:0] REG_LOST_LIM   = 3'd7;

	localparam int MAX_RECS = 6;

	typedef struct packed {
		logic [3:0] left_duty;
		logic [3:0] right_duty;
		logic       left_forward;
		logic       right_forward;
		logic [7:0] drive_periods;
		logic [6:0] beep_ms;
		logic [6:0] pause_ms;
		logic       led_level;
	} rec_t;

	typedef struct packed {
		logic [1:0] track_mode;
		logic [9:0] near_threshold;
		logic [9:0] contact_threshold;
		logic [9:0] commit_threshold;
		logic       backup_enable;
		logic [9:0] backup_after;
		logic [2:0] grace_count;
		logic [3:0] miss_allow;
	} cfg_t;

	typedef struct packed {
		logic       lock_flag;
		logic [1:0] ramp_step;
		logic [2:0] grace_left;
		logic       blink_phase;
		logic [9:0] empty_search_steps;
		logic       turn_clockwise;
		logic       prev_present;
		logic [3:0] lost_run;
		logic       centering_active;
		logic [3:0] span_seen;
		logic [9:0] held_ticks;
		logic       led_state;
	} st_t;

	localparam cfg_t CFG_RESET = '{MODE_SCAN, 10'd350, 10'd45, 10'd130, 1'b1, 10'd320,
		3'd2, 4'd5};
	localparam st_t ST_RESET = '{1'b0, 2'd0, 3'd0, 1'b0, 10'd0, 1'b1, 1'b0, 4'd0, 1'b0,
		4'd0, 10'd0, 1'b1};

	function automatic logic [3:0] ramp_val(input logic [1:0] r);
		case (r)
			2'd0: ramp_val = 4'd7;
			2'd1: ramp_val = 4'd9;
			default: ramp_val = 4'd10;
		endcase
	endfunction

	function automatic rec_t mk(input logic [3:0] ld, input logic [3:0] rd, input logic lf,
			input logic rf, input logic [7:0] per, input logic [6:0] bp,
			input logic [6:0] pz, input logic led);
		rec_t r;
		r.left_duty = ld; r.right_duty = rd; r.left_forward = lf; r.right_forward = rf;
		r.drive_periods = per; r.beep_ms = bp; r.pause_ms = pz; r.led_level = led;
		mk = r;
	endfunction
endpackage

[hw/rtl/ertt_step.sv]
// Per-ping decision logic: next state and up to six command records.
`timescale 1ns / 1ps
module ertt_step import ertt_pkg::*; #(
	parameter int SPAN_LIMIT = 10
) (
	input  cfg_t        cfg,
	input  st_t         st,
	input  logic [9:0]  ticks,
	output st_t         nst,
	output rec_t [5:0]  recs,
	output logic [2:0]  nrec
);
	localparam logic [4:0] SPAN_L = 5'(SPAN_LIMIT);

	always_comb begin
		st_t s;
		logic present;
		logic edge_m;
		logic [2:0] n;
		logic [4:0] seen;
		logic [3:0] back;
		logic finish;
		logic give_up;
		logic [3:0] fwd, inner, duty;
		logic [6:0] bp;
		logic [10:0] es;
		logic do_search, scw;
		logic [6:0] sbeep, spause;
		s = st;
		n = '0;
		recs = '0;
		present = (ticks != 10'd0) && (ticks < cfg.near_threshold);
		edge_m = (cfg.track_mode == MODE_EDGE);
		do_search = 1'b0; scw = 1'b1; sbeep = '0; spause = '0;
		finish = 1'b1; seen = '0; back = '0; give_up = 1'b0;
		fwd = '0; inner = '0; duty = '0; bp = '0; es = '0;
		case (cfg.track_mode)
			MODE_NUDGE: begin
				if (present) begin
					bp = s.lock_flag ? 7'd0 : 7'd120;
					s.empty_search_steps = '0; s.lock_flag = 1'b1; s.led_state = 1'b0;
					recs[0] = mk(4'd10, 4'd10, 1'b1, 1'b1, 8'd60, bp, 7'd0, 1'b0);
					n = 3'd1;
				end else begin
					s.lock_flag = 1'b0; s.led_state = 1'b1;
					do_search = 1'b1; spause = 7'd70;
				end
			end
			MODE_SNAKE: begin
				if (present) begin
					bp = s.lock_flag ? 7'd0 : 7'd120;
					s.empty_search_steps = '0; s.lock_flag = 1'b1; s.lost_run = '0;
					s.led_state = 1'b0;
					if (s.ramp_step < 2'd2) s.ramp_step = s.ramp_step + 2'd1;
					if (ticks < cfg.commit_threshold)
						recs[0] = mk(4'd10, 4'd10, 1'b1, 1'b1, 8'd60, bp, 7'd0, 1'b0);
					else begin
						fwd = ramp_val(s.ramp_step);
						inner = (fwd > 4'd6) ? fwd - 4'd4 : 4'd2;
						if (s.turn_clockwise)
							recs[0] = mk(fwd, inner, 1'b1, 1'b1, 8'd60, bp, 7'd0, 1'b0);
						else
							recs[0] = mk(inner, fwd, 1'b1, 1'b1, 8'd60, bp, 7'd0, 1'b0);
					end
					n = 3'd1;
				end else if (s.lock_flag) begin
					give_up = s.lost_run >= cfg.miss_allow;
					if (s.prev_present) s.turn_clockwise = ~s.turn_clockwise;
					if (s.lost_run != 4'd15) s.lost_run = s.lost_run + 4'd1;
					if (!give_up) begin
						s.led_state = 1'b0;
						recs[0] = mk(4'd9, 4'd9, s.turn_clockwise, ~s.turn_clockwise,
							8'd12, 7'd0, 7'd50, 1'b0);
					end else begin
						s.lock_flag = 1'b0; s.ramp_step = '0;
						recs[0] = mk(4'd0, 4'd0, 1'b0, 1'b0, 8'd0, 7'd60, 7'd0, s.led_state);
					end
					n = 3'd1;
				end else begin
					s.led_state = 1'b1;
					do_search = 1'b1; scw = s.turn_clockwise; spause = 7'd50;
				end
				s.prev_present = present;
			end
			default: begin
				if (edge_m && s.centering_active) begin
					if (present) begin
						seen = {1'b0, s.span_seen} + 5'd1;
						if (seen < SPAN_L) begin
							s.span_seen = seen[3:0];
							finish = 1'b0;
							recs[0] = mk(4'd10, 4'd10, 1'b1, 1'b0, 8'd12, 7'd0, 7'd50,
								s.led_state);
							n = 3'd1;
						end else
							s.span_seen = (seen > 5'd15) ? 4'd15 : seen[3:0];
					end
					if (finish) begin
						seen = {1'b0, s.span_seen} + 5'd1;
						back = seen[4:1];
						if (back > 4'd5) back = 4'd5;
						for (int i = 0; i < 5; i++)
							if (4'(i) < back)
								recs[i] = mk(4'd10, 4'd10, 1'b0, 1'b1, 8'd12, 7'd0, 7'd50,
									s.led_state);
						n = back[2:0];
						s.centering_active = 1'b0; s.lock_flag = 1'b1;
						s.grace_left = cfg.grace_count; s.led_state = 1'b0;
						s.ramp_step = 2'd1;
						duty = (s.held_ticks < cfg.contact_threshold) ? 4'd10 : 4'd9;
						recs[n] = mk(duty, duty, 1'b1, 1'b1, 8'd60, 7'd0, 7'd0, 1'b0);
						n = n + 3'd1;
					end
				end else if (present) begin
					s.empty_search_steps = '0;
					if (!s.lock_flag && edge_m) begin
						s.held_ticks = ticks; s.span_seen = 4'd1; s.centering_active = 1'b1;
						recs[0] = mk(4'd10, 4'd10, 1'b1, 1'b0, 8'd12, 7'd120, 7'd50,
							s.led_state);
						n = 3'd1;
					end else begin
						bp = '0;
						if (!s.lock_flag) begin
							recs[0] = mk(4'd9, 4'd9, 1'b1, 1'b0, 8'd20, 7'd0, 7'd0,
								s.led_state);
							n = 3'd1; bp = 7'd120; s.lock_flag = 1'b1;
						end
						s.grace_left = cfg.grace_count; s.led_state = 1'b0;
						if (s.ramp_step < 2'd2) s.ramp_step = s.ramp_step + 2'd1;
						duty = (ticks < cfg.contact_threshold) ? 4'd10 : ramp_val(s.ramp_step);
						recs[n] = mk(duty, duty, 1'b1, 1'b1, 8'd60, bp, 7'd0, 1'b0);
						n = n + 3'd1;
					end
				end else if (s.lock_flag && s.grace_left != 3'd0) begin
					duty = ramp_val(s.ramp_step);
					s.grace_left = s.grace_left - 3'd1; s.led_state = 1'b0;
					recs[0] = mk(duty, duty, 1'b1, 1'b1, 8'd60, 7'd0, 7'd0, 1'b0);
					n = 3'd1;
				end else begin
					sbeep = s.lock_flag ? 7'd60 : 7'd0;
					s.lock_flag = 1'b0; s.ramp_step = '0;
					s.blink_phase = ~s.blink_phase;
					s.led_state = ~s.blink_phase;
					do_search = 1'b1; spause = 7'd50;
				end
			end
		endcase
		if (do_search) begin
			recs[0] = mk(4'd9, 4'd9, scw, ~scw, 8'd10, sbeep, spause, s.led_state);
			n = 3'd1;
			if (cfg.backup_enable) begin
				es = {1'b0, s.empty_search_steps} + 11'd1;
				if (es >= {1'b0, cfg.backup_after}) begin
					s.empty_search_steps = '0;
					recs[1] = mk(4'd8, 4'd8, 1'b0, 1'b0, 8'd150, 7'd0, 7'd50, s.led_state);
					n = 3'd2;
				end else
					s.empty_search_steps = es[9:0];
			end
		end
		nst = s;
		nrec = n;
	end
endmodule

[hw/rtl/echo_range_target_tracker_top.sv]
// Top level of the echo range target tracker: config port, state, record queue.
//
//   channel   | valid      | stall      | payload
//   ----------+------------+------------+---------------------------------
//   ping in   | echo_valid | echo_stall | echo_ticks
//   record out| rec_valid  | rec_stall  | left_duty .. led_level, last_record
//   config    | APB psel/penable/pwrite/paddr/pwdata, prdata, pready=1
//
// A ping is decided in the cycle it is accepted: state updates at once and its
// one to six records land in a record buffer, which emits one beat per cycle
// while rec_stall is low. A ping holds the buffer until its last record leaves,
// so the drain sets the rate; a new ping is taken in the cycle the last beat leaves.
// Reset clears state to power-up values and empties the buffer.
// A stalled record holds until taken.
`timescale 1ns / 1ps
module echo_range_target_tracker_top import ertt_pkg::*; #(
	parameter int SPAN_LIMIT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        echo_valid,
	output logic        echo_stall,
	input  logic [9:0]  echo_ticks,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic [3:0]  left_duty,
	output logic [3:0]  right_duty,
	output logic        left_forward,
	output logic        right_forward,
	output logic [7:0]  drive_periods,
	output logic [6:0]  beep_ms,
	output logic [6:0]  pause_ms,
	output logic        led_level,
	output logic        last_record
);
	cfg_t cfg_q;
	st_t  st_q, nst;
	rec_t [5:0] recs, buf_q;
	logic [2:0] nrec, cnt_q, idx_q;
	logic take, pop, last;
	logic [2:0] ra;

	assign pready = 1'b1;
	assign ra = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (ra)
				REG_TRACK_MODE: cfg_q.track_mode <= pwdata[1:0];
				REG_NEAR:       cfg_q.near_threshold <= pwdata[9:0];
				REG_CONTACT:    cfg_q.contact_threshold <= pwdata[9:0];
				REG_COMMIT:     cfg_q.commit_threshold <= pwdata[9:0];
				REG_BACKUP_EN:  cfg_q.backup_enable <= pwdata[0];
				REG_BACKUP_AFT: cfg_q.backup_after <= pwdata[9:0];
				REG_GRACE:      cfg_q.grace_count <= pwdata[2:0];
				REG_LOST_LIM:   cfg_q.miss_allow <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ra)
			REG_TRACK_MODE: prdata = {30'd0, cfg_q.track_mode};
			REG_NEAR:       prdata = {22'd0, cfg_q.near_threshold};
			REG_CONTACT:    prdata = {22'd0, cfg_q.contact_threshold};
			REG_COMMIT:     prdata = {22'd0, cfg_q.commit_threshold};
			REG_BACKUP_EN:  prdata = {31'd0, cfg_q.backup_enable};
			REG_BACKUP_AFT: prdata = {22'd0, cfg_q.backup_after};
			REG_GRACE:      prdata = {29'd0, cfg_q.grace_count};
			REG_LOST_LIM:   prdata = {28'd0, cfg_q.miss_allow};
			default:        prdata = '0;
		endcase
	end

	ertt_step #(.SPAN_LIMIT(SPAN_LIMIT)) u_step (
		.cfg(cfg_q), .st(st_q), .ticks(echo_ticks), .nst(nst), .recs(recs), .nrec(nrec)
	);

	// Buffer holds the current ping's records; idx points at the beat on show.
	assign rec_valid  = (cnt_q != 3'd0);
	assign last       = (idx_q + 3'd1 == cnt_q);
	assign pop        = rec_valid && !rec_stall;
	assign echo_stall = rec_valid && !(pop && last);
	assign take       = echo_valid && !echo_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			st_q  <= nst;
			cnt_q <= nrec;
			idx_q <= '0;
		end else if (pop) begin
			if (last) cnt_q <= '0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) buf_q <= recs;
	end

	always_comb begin
		rec_t r;
		r = buf_q[0];
		for (int i = 0; i < MAX_RECS; i++)
			if (idx_q == 3'(i)) r = buf_q[i];
		left_duty = r.left_duty;
		right_duty = r.right_duty;
		left_forward = r.left_forward;
		right_forward = r.right_forward;
		drive_periods = r.drive_periods;
		beep_ms = r.beep_ms;
		pause_ms = r.pause_ms;
		led_level = r.led_level;
		last_record = last;
	end
endmodule
